// ===== design/hte_pkg.sv =====
// hte_pkg: shared types and constants for the table-driven Huffman encoder.
// No dependencies; every other design file but hte_ram refers to it by scoped names.

package hte_pkg;

    // default build values for the top-level parameters
    localparam int MAX_CODE_LEN_DFLT = 32;
    localparam int SYMBOLS_DFLT      = 256;

    // fixed field widths of the channels
    localparam int CMD_W  = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int PAD_W  = 3;

    // input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_MERGE,
        ST_EMIT,
        ST_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_wr;   // write a table entry from the input transaction
        logic enc_rd;    // start a table read for an encode
        logic align;     // left-align the looked-up code
        logic merge;     // append the code to the bit window
        logic shift;     // a byte left the window
        logic clear;     // stream finished, empty the window
        logic fin_sel;   // result payload is the final byte
    } t_dp_ctl;

    // datapath status back to the controller
    typedef struct packed {
        logic ge8;       // at least one full byte pending
        logic lt16;      // the pending full byte is the last one
    } t_dp_sts;

endpackage

// ===== design/hte_in_if.sv =====
// hte_in_if: input channel of the Huffman encoder (command transactions).
// Depends on hte_pkg for the field widths.

interface hte_in_if;
    logic                          valid;
    logic                          ready;
    logic [hte_pkg::CMD_W-1:0]     cmd;
    logic [hte_pkg::SYM_W-1:0]     symbol;
    logic [hte_pkg::CODE_W-1:0]    code_bits;
    logic [hte_pkg::LEN_W-1:0]     code_len;

    modport source (output valid, cmd, symbol, code_bits, code_len, input ready);
    modport sink   (input valid, cmd, symbol, code_bits, code_len, output ready);
endinterface

// ===== design/hte_out_if.sv =====
// hte_out_if: output channel of the Huffman encoder (packed byte transactions).
// Depends on hte_pkg for the field widths.

interface hte_out_if;
    logic                          valid;
    logic                          ready;
    logic [hte_pkg::BYTE_W-1:0]    out_byte;
    logic [hte_pkg::PAD_W-1:0]     pad_bits;
    logic                          end_of_stream;
    logic                          last_in_run;

    modport source (output valid, out_byte, pad_bits, end_of_stream, last_in_run,
                    input ready);
    modport sink   (input valid, out_byte, pad_bits, end_of_stream, last_in_run,
                    output ready);
endinterface

// ===== design/hte_ram.sv =====
// hte_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module hte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/hte_ctrl.sv =====
// hte_ctrl: sequencing state machine of the Huffman encoder.
// Depends on hte_pkg (state, command codes, control/status structs).

module hte_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [hte_pkg::CMD_W-1:0] i_in_cmd,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output hte_pkg::t_dp_ctl          o_ctl,
    input  hte_pkg::t_dp_sts          i_sts
);

    hte_pkg::t_state r_state;
    hte_pkg::t_state n_state;
    logic            in_acc;
    logic            out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hte_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hte_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_cmd)
                        hte_pkg::CMD_ENCODE: n_state = hte_pkg::ST_ALIGN;
                        hte_pkg::CMD_FINISH: n_state = hte_pkg::ST_FINISH;
                        default:             n_state = hte_pkg::ST_IDLE;
                    endcase
                end
            end
            hte_pkg::ST_ALIGN: n_state = hte_pkg::ST_MERGE;
            hte_pkg::ST_MERGE: n_state = hte_pkg::ST_EMIT;
            hte_pkg::ST_EMIT: begin
                if (!i_sts.ge8) begin
                    n_state = hte_pkg::ST_IDLE;
                end else if (out_acc && i_sts.lt16) begin
                    n_state = hte_pkg::ST_IDLE;
                end
            end
            hte_pkg::ST_FINISH: begin
                if (out_acc) begin
                    n_state = hte_pkg::ST_IDLE;
                end
            end
            default: n_state = hte_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctl       = '0;
        case (r_state)
            hte_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctl.load_wr = in_acc && (i_in_cmd == hte_pkg::CMD_LOAD);
                o_ctl.enc_rd  = in_acc && (i_in_cmd == hte_pkg::CMD_ENCODE);
            end
            hte_pkg::ST_ALIGN: o_ctl.align = 1'b1;
            hte_pkg::ST_MERGE: o_ctl.merge = 1'b1;
            hte_pkg::ST_EMIT: begin
                o_out_valid = i_sts.ge8;
                o_ctl.shift = out_acc;
            end
            hte_pkg::ST_FINISH: begin
                o_out_valid   = 1'b1;
                o_ctl.fin_sel = 1'b1;
                o_ctl.clear   = out_acc;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/hte_dp.sv =====
// hte_dp: code table and bit-packing datapath of the Huffman encoder.
// Depends on hte_pkg and hte_ram.

module hte_dp #(
    parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DFLT,
    parameter int SYMBOLS      = hte_pkg::SYMBOLS_DFLT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hte_pkg::t_dp_ctl           i_ctl,
    output hte_pkg::t_dp_sts           o_sts,
    input  logic [hte_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hte_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hte_pkg::LEN_W-1:0]  i_code_len,
    output logic [hte_pkg::BYTE_W-1:0] o_out_byte,
    output logic [hte_pkg::PAD_W-1:0]  o_pad_bits,
    output logic                       o_end_of_stream,
    output logic                       o_last_in_run
);

    localparam int IW = $clog2(SYMBOLS);            // table index
    localparam int LW = $clog2(MAX_CODE_LEN + 1);   // stored length
    localparam int EW = LW + MAX_CODE_LEN;          // table entry
    localparam int WW = MAX_CODE_LEN + 8;           // bit window
    localparam int TW = $clog2(WW);                 // window fill count
    localparam logic [hte_pkg::SYM_W:0] SymLimit  = (hte_pkg::SYM_W + 1)'(SYMBOLS);
    localparam logic [hte_pkg::LEN_W-1:0] LenMax  = hte_pkg::LEN_W'(MAX_CODE_LEN);

    logic                          sym_ok;
    logic [hte_pkg::LEN_W-1:0]     len_sat;
    logic [hte_pkg::CODE_W-1:0]    code_mask;
    logic [EW-1:0]                 wdata;
    logic [EW-1:0]                 rdata;
    logic [LW-1:0]                 rd_len;
    logic [MAX_CODE_LEN-1:0]       rd_code;
    logic [LW-1:0]                 clen;

    logic                          r_sym_ok;
    logic [LW-1:0]                 r_clen;
    logic [MAX_CODE_LEN-1:0]       r_code;
    logic [WW-1:0]                 r_win;
    logic [TW-1:0]                 r_total;

    // symbol range check and load entry formatting
    assign sym_ok    = {1'b0, i_symbol} < SymLimit;
    assign len_sat   = (i_code_len > LenMax) ? LenMax : i_code_len;
    assign code_mask = ~({hte_pkg::CODE_W{1'b1}} << len_sat);
    assign wdata     = {LW'(len_sat), MAX_CODE_LEN'(i_code_bits & code_mask)};

    // code table
    hte_ram #(
        .WIDTH (EW),
        .DEPTH (SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_ctl.load_wr && sym_ok),
        .i_waddr (i_symbol[IW-1:0]),
        .i_wdata (wdata),
        .i_re    (i_ctl.enc_rd),
        .i_raddr (i_symbol[IW-1:0]),
        .o_rdata (rdata)
    );

    assign rd_len  = rdata[EW-1 -: LW];
    assign rd_code = rdata[MAX_CODE_LEN-1:0];
    // out-of-range symbols encode as an empty code
    assign clen    = r_sym_ok ? rd_len : '0;

    // lookup capture and code alignment
    always_ff @(posedge i_clk) begin
        if (i_ctl.enc_rd) begin
            r_sym_ok <= sym_ok;
        end
        if (i_ctl.align) begin
            r_clen <= clen;
            r_code <= rd_code << (LW'(MAX_CODE_LEN) - clen);
        end
    end

    // bit window: pending bits left-aligned, low bits always zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_total <= '0;
        end else if (i_ctl.clear) begin
            r_win   <= '0;
            r_total <= '0;
        end else if (i_ctl.merge) begin
            r_win   <= r_win | ({r_code, 8'b0} >> r_total);
            r_total <= r_total + TW'(r_clen);
        end else if (i_ctl.shift) begin
            r_win   <= r_win << 8;
            r_total <= r_total - TW'(8);
        end
    end

    // status
    assign o_sts.ge8  = {1'b0, r_total} >= (TW + 1)'(8);
    assign o_sts.lt16 = {1'b0, r_total} <  (TW + 1)'(16);

    // result payload
    assign o_out_byte      = r_win[WW-1 -: hte_pkg::BYTE_W];
    assign o_pad_bits      = i_ctl.fin_sel ? hte_pkg::PAD_W'(4'd8 - {1'b0, r_total[2:0]})
                                           : '0;
    assign o_end_of_stream = i_ctl.fin_sel;
    assign o_last_in_run   = i_ctl.fin_sel || o_sts.lt16;

endmodule

// ===== design/huffman_table_encoder.sv =====
// huffman_table_encoder: top level of the table-driven Huffman encoder.
// Depends on hte_pkg, hte_in_if, hte_out_if, hte_ctrl and hte_dp.
//
// Usage:
//   i_in carries command transactions: load (write one code table entry),
//   encode (append the code of a byte) and finish (flush the last byte).
//   o_out carries packed bytes, earliest bit in the MSB; the finish result
//   has end_of_stream set and reports the zero pad count in pad_bits.
//   last_in_run marks the final byte caused by one input transaction.
// Timing:
//   One transaction is worked on at a time; i_in.ready is high only when idle.
//   A load writes its table entry. An encode steps through the table read,
//   code align and window merge, then emits its output bytes (1 to 4), or
//   makes a single empty check when it completes no byte; a byte leaves per
//   cycle on o_out while o_out.ready is high. A finish gives a single result.
// Reset:
//   Clears the bit window and the controller; the code table is not cleared
//   and each entry must be loaded before it is encoded.
// Stalls:
//   While o_out.ready is low the pending result holds in the window register
//   and no new input is taken.

module huffman_table_encoder #(
    parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DFLT,
    parameter int SYMBOLS      = hte_pkg::SYMBOLS_DFLT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hte_in_if.sink     i_in,
    hte_out_if.source  o_out
);

    hte_pkg::t_dp_ctl ctl;
    hte_pkg::t_dp_sts sts;

    // controller
    hte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    // datapath
    hte_dp #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOLS      (SYMBOLS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_symbol        (i_in.symbol),
        .i_code_bits     (i_in.code_bits),
        .i_code_len      (i_in.code_len),
        .o_out_byte      (o_out.out_byte),
        .o_pad_bits      (o_out.pad_bits),
        .o_end_of_stream (o_out.end_of_stream),
        .o_last_in_run   (o_out.last_in_run)
    );

endmodule
